/* src/sdrx_pkg.sv */
// Shared types, codes and the CRC16-CCITT byte update for the SD SPI block receiver.
package sdrx_pkg;

    localparam logic [7:0]  TOKEN_START = 8'hFE;
    localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] ERR_MAX     = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] REG_BLOCK_LEN  = 2'd0;
    localparam logic [1:0] REG_WAIT_LIMIT = 2'd1;

    localparam logic [9:0]  BLOCK_LEN_RESET  = 10'd512;
    localparam logic [15:0] WAIT_LIMIT_RESET = 16'd4096;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DATA   = 2'd1,
        PH_CRC_HI = 2'd2,
        PH_CRC_LO = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TOKEN = 2'd1,
        ST_TIMEOUT   = 2'd2,
        ST_CRC_BAD   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_data;
        status_t     block_status;
        logic        last;
        logic [15:0] crc_error_total;
    } result_t;

    // CRC16-CCITT, MSB first, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                                input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* src/sdrx_in_stage.sv */
// Input register stage: holds one received byte until the core takes it.
module sdrx_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Accept when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* src/sdrx_core.sv */
// Block receiver core: token hunt, payload CRC, trailer compare and configuration registers.
module sdrx_core
#(
    parameter int MAX_BLOCK_BYTES = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output sdrx_pkg::result_t res
);

    localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int LEN_W = (CNT_W > 10) ? CNT_W : 10;

    logic [9:0]       block_len_reg;
    logic [15:0]      wait_limit_reg;

    sdrx_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      wait_count_reg, wait_count_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [15:0]      err_count_reg, err_count_next;

    logic [15:0]      wait_inc;
    logic             timeout_hit;
    logic [CNT_W-1:0] count_inc;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] len_ext;
    logic             block_done;
    logic [15:0]      crc_upd;
    logic             crc_match;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg  <= sdrx_pkg::BLOCK_LEN_RESET;
            wait_limit_reg <= sdrx_pkg::WAIT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sdrx_pkg::REG_BLOCK_LEN:  block_len_reg  <= cfg_data[9:0];
                sdrx_pkg::REG_WAIT_LIMIT: wait_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the block length to 1..MAX_BLOCK_BYTES
    always_comb
    begin
        len_ext = LEN_W'(block_len_reg);
        if (len_ext == '0)
            eff_len = LEN_W'(1);
        else if (len_ext > LEN_W'(MAX_BLOCK_BYTES))
            eff_len = LEN_W'(MAX_BLOCK_BYTES);
        else
            eff_len = len_ext;
    end

    assign wait_inc    = wait_count_reg + 16'd1;
    assign timeout_hit = (wait_inc >= wait_limit_reg) || (wait_inc == 16'd0);
    assign count_inc   = byte_count_reg + CNT_W'(1);
    assign block_done  = LEN_W'(count_inc) >= eff_len;
    assign crc_upd     = sdrx_pkg::crc16_byte(crc_reg, rx_byte);
    assign crc_match   = {crc_hi_reg, rx_byte} == crc_reg;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            sdrx_pkg::PH_HUNT:
                if (rx_byte == sdrx_pkg::TOKEN_START)
                    phase_next = sdrx_pkg::PH_DATA;
            sdrx_pkg::PH_DATA:
                if (block_done)
                    phase_next = sdrx_pkg::PH_CRC_HI;
            sdrx_pkg::PH_CRC_HI:
                phase_next = sdrx_pkg::PH_CRC_LO;
            sdrx_pkg::PH_CRC_LO:
                phase_next = sdrx_pkg::PH_HUNT;
            default:
                phase_next = sdrx_pkg::PH_HUNT;
        endcase
    end

    // Datapath updates and the result for this byte
    always_comb
    begin
        wait_count_next = wait_count_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        crc_hi_next     = crc_hi_reg;
        err_count_next  = err_count_reg;
        res_valid       = 1'b0;
        res.data_byte    = 8'h00;
        res.is_data      = 1'b0;
        res.block_status = sdrx_pkg::ST_OK;
        res.last         = 1'b0;
        case (phase_reg)
            sdrx_pkg::PH_HUNT:
            begin
                if (rx_byte == sdrx_pkg::IDLE_BYTE)
                begin
                    if (timeout_hit)
                    begin
                        wait_count_next  = 16'd0;
                        res_valid        = 1'b1;
                        res.block_status = sdrx_pkg::ST_TIMEOUT;
                        res.last         = 1'b1;
                    end
                    else
                        wait_count_next = wait_inc;
                end
                else
                begin
                    wait_count_next = 16'd0;
                    if (rx_byte == sdrx_pkg::TOKEN_START)
                    begin
                        byte_count_next = '0;
                        crc_next        = 16'd0;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.block_status = sdrx_pkg::ST_BAD_TOKEN;
                        res.last         = 1'b1;
                    end
                end
            end
            sdrx_pkg::PH_DATA:
            begin
                crc_next        = crc_upd;
                byte_count_next = count_inc;
                res_valid       = 1'b1;
                res.data_byte   = rx_byte;
                res.is_data     = 1'b1;
            end
            sdrx_pkg::PH_CRC_HI:
                crc_hi_next = rx_byte;
            sdrx_pkg::PH_CRC_LO:
            begin
                wait_count_next = 16'd0;
                byte_count_next = '0;
                res_valid       = 1'b1;
                res.last        = 1'b1;
                if (!crc_match)
                begin
                    res.block_status = sdrx_pkg::ST_CRC_BAD;
                    if (err_count_reg != sdrx_pkg::ERR_MAX)
                        err_count_next = err_count_reg + 16'd1;
                end
            end
            default: ;
        endcase
        res.crc_error_total = err_count_next;
    end

    // Commit state when the byte is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sdrx_pkg::PH_HUNT;
            wait_count_reg <= 16'd0;
            byte_count_reg <= '0;
            crc_reg        <= 16'd0;
            crc_hi_reg     <= 8'h00;
            err_count_reg  <= 16'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            crc_hi_reg     <= crc_hi_next;
            err_count_reg  <= err_count_next;
        end
    end

endmodule

/* src/sdrx_out_stage.sv */
// Output register stage: holds one result until the downstream side takes it.
module sdrx_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sdrx_pkg::result_t res,
    output logic              advance_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output sdrx_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    sdrx_pkg::result_t res_reg;

    // Free when empty or when the held result is taken this cycle
    assign advance_ok = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* src/sd_spi_data_block_receiver.sv */
// Top level of the SD SPI-mode data block receiver.
//
// Slave stream (s_axis_*) carries bytes read from the card, one per transaction.
// The receiver skips 0xFF idle bytes while hunting for the 0xFE start token,
// reports a bad token for any other byte and a timeout once token_wait_limit
// idle bytes have gone by. After the token it forwards block_len payload bytes
// with is_data set, runs a CRC16-CCITT over them and closes the block with an
// ok or CRC-mismatch status (tlast high) after the two trailing CRC bytes.
// Token, CRC high byte and idle bytes below the limit give no result.
// Configuration: cfg_index 0 is block_len, 1 is token_wait_limit; cfg_ready is
// always high. Writes must be made while the block is idle; the block itself
// does not enforce this. A result goes through the input and result registers
// to the master stream. Throughput: one byte per cycle while the master side
// does not stall, set by the byte-wide CRC update between the input and result
// registers. Reset clears the phase, counters, CRC and error total and loads the
// register defaults (512, 4096). When the master side stalls, both registers
// hold and s_axis_tready drops once the input register is full.
module sd_spi_data_block_receiver
#(
    parameter int MAX_BLOCK_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Byte input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] crc_error_total
    output logic [2:0]  m_axis_tuser,   // [0] is_data, [2:1] block_status
    output logic        m_axis_tlast    // last
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              advance_ok;
    logic              advance;
    logic              res_valid;
    sdrx_pkg::result_t core_res;
    sdrx_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign advance   = held_valid && advance_ok;

    sdrx_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sdrx_core #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .rx_byte   (held_byte),
        .res_valid (res_valid),
        .res       (core_res)
    );

    sdrx_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res_valid),
        .res        (core_res),
        .advance_ok (advance_ok),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    // Pack the result fields onto the stream
    assign m_axis_tdata = {out_res.crc_error_total, out_res.data_byte};
    assign m_axis_tuser = {out_res.block_status, out_res.is_data};
    assign m_axis_tlast = out_res.last;

endmodule

/* test/sd_spi_data_block_receiver_test.sv */
// Self-checking testbench for the SD SPI-mode data block receiver.
`timescale 1ns / 100ps

module sd_spi_data_block_receiver_test;

    localparam int MAX_BYTES     = 512;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF      = 300;
    localparam int RANDOM_BYTES  = 440;

    // Register indexes outside the defined list
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] data_byte, [23:8] crc_error_total
    logic [2:0]  m_axis_tuser;   // [0] is_data, [2:1] block_status
    logic        m_axis_tlast;   // last

    // Predicted receiver state and register copies
    logic [9:0]        blk_len_reg    = sdrx_pkg::BLOCK_LEN_RESET;
    logic [15:0]       wait_limit_reg = sdrx_pkg::WAIT_LIMIT_RESET;
    sdrx_pkg::phase_t  ph             = sdrx_pkg::PH_HUNT;
    logic [15:0]       wait_cnt       = '0;
    int                byte_cnt       = 0;
    logic [15:0]       crc_acc        = '0;
    logic [7:0]        crc_hi         = '0;
    logic [15:0]       err_total      = '0;

    sdrx_pkg::result_t due_outputs[$];
    logic [7:0]        frame_buf[0:MAX_BYTES-1];

    int  fails         = 0;
    int  n_bytes       = 0;
    int  n_results     = 0;
    int  block_ends[4] = '{0, 0, 0, 0};
    int  quiet_cycles  = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_en    = 1'b0;
    bit  rx_idle_en    = 1'b0;

    sd_spi_data_block_receiver #(.MAX_BLOCK_BYTES(MAX_BYTES)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // CRC16-CCITT, one bit at a time, MSB of the byte first
    function automatic logic [15:0] ccitt_next(input logic [15:0] acc, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ sdrx_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    // Clamp the programmed length to 1..MAX_BYTES
    function automatic int block_bytes(input logic [9:0] n);
        if (n == 10'd0)
            return 1;
        if (n > MAX_BYTES)
            return MAX_BYTES;
        return int'(n);
    endfunction

    // Advance the block state by one card byte and queue any output it causes
    task automatic advance_block_state(input logic [7:0] b);
        sdrx_pkg::result_t r;
        bit                hit;
        r   = '0;
        hit = 1'b0;
        case (ph)
            sdrx_pkg::PH_HUNT:
            begin
                if (b == sdrx_pkg::IDLE_BYTE)
                begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= wait_limit_reg || wait_cnt == 16'd0)
                    begin
                        wait_cnt       = '0;
                        r.block_status = sdrx_pkg::ST_TIMEOUT;
                        r.last         = 1'b1;
                        hit            = 1'b1;
                    end
                end
                else
                begin
                    wait_cnt = '0;
                    if (b == sdrx_pkg::TOKEN_START)
                    begin
                        ph       = sdrx_pkg::PH_DATA;
                        byte_cnt = 0;
                        crc_acc  = '0;
                    end
                    else
                    begin
                        r.block_status = sdrx_pkg::ST_BAD_TOKEN;
                        r.last         = 1'b1;
                        hit            = 1'b1;
                    end
                end
            end
            sdrx_pkg::PH_DATA:
            begin
                crc_acc  = ccitt_next(crc_acc, b);
                byte_cnt = byte_cnt + 1;
                if (byte_cnt >= block_bytes(blk_len_reg))
                    ph = sdrx_pkg::PH_CRC_HI;
                r.data_byte = b;
                r.is_data   = 1'b1;
                hit         = 1'b1;
            end
            sdrx_pkg::PH_CRC_HI:
            begin
                crc_hi = b;
                ph     = sdrx_pkg::PH_CRC_LO;
            end
            default:
            begin
                ph       = sdrx_pkg::PH_HUNT;
                wait_cnt = '0;
                byte_cnt = 0;
                if ({crc_hi, b} != crc_acc)
                begin
                    if (err_total != sdrx_pkg::ERR_MAX)
                        err_total = err_total + 16'd1;
                    r.block_status = sdrx_pkg::ST_CRC_BAD;
                end
                else
                begin
                    r.block_status = sdrx_pkg::ST_OK;
                end
                r.last = 1'b1;
                hit    = 1'b1;
            end
        endcase
        r.crc_error_total = err_total;
        if (hit)
            due_outputs.push_back(r);
    endtask

    // Offer one byte, with an occasional gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_block_state(b);
        n_bytes++;
    endtask

    // Token, frame_buf payload, then the CRC (optionally corrupted)
    task automatic send_frame(input int len, input bit bad_crc);
        logic [15:0] c;
        c = '0;
        send_byte(sdrx_pkg::TOKEN_START);
        for (int i = 0; i < len; i++)
        begin
            c = ccitt_next(c, frame_buf[i]);
            send_byte(frame_buf[i]);
        end
        if (bad_crc)
            c = c ^ 16'($urandom_range(1, 65535));
        send_byte(c[15:8]);
        send_byte(c[7:0]);
    endtask

    task automatic fill_frame(input int len);
        for (int i = 0; i < len; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
    endtask

    // Stop offering and wait until every predicted output has come out
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sdrx_pkg::REG_BLOCK_LEN:  blk_len_reg    = val[9:0];
            sdrx_pkg::REG_WAIT_LIMIT: wait_limit_reg = val;
            default: ;
        endcase
    endtask

    // Reset values: idle bytes well short of the default limit, then a stray byte
    task automatic test_reset_defaults;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (20) send_byte(sdrx_pkg::IDLE_BYTE);
        send_byte(8'h3C);
        settle();
    endtask

    // Short hand-picked sequence over every status and the no-output bytes
    task automatic test_directed_cases;
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd4);
        write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd3);
        send_byte(sdrx_pkg::IDLE_BYTE);
        send_byte(sdrx_pkg::IDLE_BYTE);
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'hFF;
        frame_buf[2] = 8'h80;
        frame_buf[3] = 8'h7F;
        send_frame(4, 1'b0);
        send_byte(8'hFD);
        send_byte(8'h00);
        repeat (3) send_byte(sdrx_pkg::IDLE_BYTE);
        send_byte(sdrx_pkg::IDLE_BYTE);
        fill_frame(4);
        send_frame(4, 1'b1);
        settle();
    endtask

    // Register extremes, clamping and writes to unused indexes
    task automatic test_register_edges;
        write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd0);
        repeat (3) send_byte(sdrx_pkg::IDLE_BYTE);
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd0);
        fill_frame(1);
        send_frame(1, 1'b0);
        write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_B, 16'hFFFF);
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd5);
        fill_frame(5);
        send_frame(5, 1'b0);
        // Widest limit: a short idle run gives nothing
        write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'hFFFF);
        repeat (10) send_byte(sdrx_pkg::IDLE_BYTE);
        settle();
    endtask

    // Shorten the block while its payload is partly received
    task automatic test_length_change_mid_block;
        logic [15:0] c;
        logic [7:0]  d;
        c = '0;
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd8);
        send_byte(sdrx_pkg::TOKEN_START);
        repeat (3)
        begin
            d = 8'($urandom_range(0, 255));
            c = ccitt_next(c, d);
            send_byte(d);
        end
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd2);
        d = 8'($urandom_range(0, 255));
        c = ccitt_next(c, d);
        send_byte(d);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        settle();
    endtask

    // Hold the result side off while bytes keep coming, then drain fully
    task automatic test_backpressure;
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd32);
        write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd100);
        tx_idle_en     = 1'b0;
        rx_hold_cycles = HOLD_OFF;
        fill_frame(32);
        send_frame(32, 1'b0);
        settle();
        tx_idle_en = 1'b1;
        fill_frame(32);
        send_frame(32, 1'b1);
        settle();
    endtask

    // Mostly well-formed blocks with random content, plus idle runs and noise
    task automatic test_random_traffic;
        int start_bytes;
        int cfg_mark;
        int pick;
        int len;
        int n;
        start_bytes = n_bytes;
        cfg_mark    = n_bytes - 1000;
        while (n_bytes - start_bytes < RANDOM_BYTES)
        begin
            // Move to a new setting every so often
            if (n_bytes - cfg_mark >= 120)
            begin
                cfg_mark = n_bytes;
                case ($urandom_range(0, 3))
                    0: write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd1);
                    1: write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd2);
                    2: write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'($urandom_range(3, 16)));
                    default: write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd40);
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd1);
                    1: write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd2);
                    2: write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'($urandom_range(3, 30)));
                    default: write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'hFFFF);
                endcase
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_idle_en = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                repeat ($urandom_range(0, 2)) send_byte(sdrx_pkg::IDLE_BYTE);
                len = block_bytes(blk_len_reg);
                fill_frame(len);
                send_frame(len, $urandom_range(0, 4) == 0);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(1, 40);
                repeat (n) send_byte(sdrx_pkg::IDLE_BYTE);
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        settle();
    endtask

    // Count CRC mismatches over minimal back-to-back blocks, no idling
    task automatic test_crc_error_count;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(sdrx_pkg::REG_BLOCK_LEN, 16'd1);
        write_reg(sdrx_pkg::REG_WAIT_LIMIT, 16'd16);
        // Realign to the hunting state first
        while (ph != sdrx_pkg::PH_HUNT)
            send_byte(8'($urandom_range(0, 255)));
        repeat (6)
        begin
            fill_frame(1);
            send_frame(1, 1'b1);
        end
        fill_frame(1);
        send_frame(1, 1'b0);
        settle();
    endtask

    // Result side: ready with random stall bursts, or a long requested hold-off
    initial
    begin
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_outputs
        sdrx_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_outputs.size() == 0)
            begin
                $error("result with nothing predicted: tdata %h tuser %h tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fails++;
            end
            else
            begin
                want = due_outputs.pop_front();
                n_results++;
                if (want.last)
                    block_ends[want.block_status]++;
                if (m_axis_tdata[7:0] !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte,
                           m_axis_tdata[7:0]);
                    fails++;
                end
                if (m_axis_tuser[0] !== want.is_data)
                begin
                    $error("is_data: expected %0d, got %0d", want.is_data, m_axis_tuser[0]);
                    fails++;
                end
                if (m_axis_tuser[2:1] !== want.block_status)
                begin
                    $error("block_status: expected %0d, got %0d", want.block_status,
                           m_axis_tuser[2:1]);
                    fails++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fails++;
                end
                if (m_axis_tdata[23:8] !== want.crc_error_total)
                begin
                    $error("crc_error_total: expected %0d, got %0d", want.crc_error_total,
                           m_axis_tdata[23:8]);
                    fails++;
                end
            end
        end
    end

    // End the run if no transaction of any kind completes for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= sdrx_pkg::REG_BLOCK_LEN;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_register_edges();
        test_length_change_mid_block();
        test_backpressure();
        test_random_traffic();
        test_crc_error_count();

        settle();
        $display("Sent %0d card bytes, checked %0d results (%0d ok, %0d bad token,",
                 n_bytes, n_results, block_ends[sdrx_pkg::ST_OK],
                 block_ends[sdrx_pkg::ST_BAD_TOKEN]);
        $display("%0d timeout, %0d CRC mismatch blocks); error total ended at %0d",
                 block_ends[sdrx_pkg::ST_TIMEOUT], block_ends[sdrx_pkg::ST_CRC_BAD],
                 err_total);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
